FILE: hw/rtl/ftl_pkg.sv
// types and constants shared by the page map table
`default_nettype none
package ftl_pkg;

  localparam int unsigned FOLD_SHIFT = 24;

  // reverse table size, fixed at build time; must stay a power of two so the
  // slot is the low bits of the folded page
  localparam int unsigned REVERSE_DEPTH = 65536;

  typedef enum logic [3:0] {
    CMD_LOOKUP   = 4'd0,
    CMD_RLOOKUP  = 4'd1,
    CMD_INSERT   = 4'd2,
    CMD_REMOVE   = 4'd3,
    CMD_UPDATE   = 4'd4,
    CMD_SET      = 4'd5,
    CMD_CLEAR    = 4'd6,
    CMD_REBUILD  = 4'd7,
    CMD_COUNT    = 4'd8
  } ftl_cmd_t;

  typedef enum logic [1:0] {
    STS_OK      = 2'd0,
    STS_INVALID = 2'd1,
    STS_NOENT   = 2'd2
  } ftl_sts_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_FEXEC,
    ST_SLOT,
    ST_RRD,
    ST_RCLR,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_RESP
  } ftl_state_t;

  typedef enum logic [1:0] {
    PH_OLD,
    PH_NEW,
    PH_RLK,
    PH_SCAN
  } ftl_phase_t;

  typedef struct packed {
    logic [3:0]  command;
    logic [31:0] logical_block;
    logic [63:0] physical_page;
  } ftl_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] page_out;
    logic        old_page_valid;
    logic [15:0] block_out;
    logic [31:0] mapped_count;
  } ftl_out_t;

endpackage
`default_nettype wire

FILE: hw/rtl/ftl_page_map_table.sv
// flash page map: forward and reverse tables in synchronous memories
// one command at a time; in_ready is high only in the idle state, so the next beat is taken only
//   after the result of the last one has moved into the output register
// the result is valid in the same cycle that in_ready rises, once the output register is free
// rebuild: clears the reverse table, then refills it from each valid forward entry below the limit
// reset: a clearing pass wipes both tables first
`default_nettype none
module ftl_page_map_table #(
  parameter int unsigned FORWARD_DEPTH = 65536
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire ftl_pkg::ftl_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output ftl_pkg::ftl_out_t      out_data,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [16:0]       cfg_data
);
  import ftl_pkg::*;

  // address widths of the two tables
  localparam int unsigned FAW  = (FORWARD_DEPTH > 1) ? $clog2(FORWARD_DEPTH) : 1;
  localparam int unsigned RAW  = (REVERSE_DEPTH > 1) ? $clog2(REVERSE_DEPTH) : 1;
  localparam int unsigned MAXD = (FORWARD_DEPTH > REVERSE_DEPTH) ? FORWARD_DEPTH
                                                                 : REVERSE_DEPTH;
  localparam int unsigned IW   = $clog2(MAXD) + 1;
  localparam logic [31:0] FD32 = 32'(FORWARD_DEPTH);
  localparam logic [31:0] RD32 = 32'(REVERSE_DEPTH);
  localparam logic [31:0] MD32 = 32'(MAXD);

  // forward entry {valid, page}, reverse entry {valid, block}
  logic [64:0] fwd_mem [FORWARD_DEPTH];
  logic [16:0] rev_mem [REVERSE_DEPTH];

  logic            fwd_we;
  logic [FAW-1:0]  fwd_wa, fwd_ra;
  logic [64:0]     fwd_wd, fwd_q_r;
  logic            rev_we;
  logic [RAW-1:0]  rev_wa, rev_ra;
  logic [16:0]     rev_wd, rev_q_r;

  always_ff @(posedge clk) begin
    if (fwd_we) begin
      fwd_mem[fwd_wa] <= fwd_wd;
    end
    fwd_q_r <= fwd_mem[fwd_ra];
  end

  always_ff @(posedge clk) begin
    if (rev_we) begin
      rev_mem[rev_wa] <= rev_wd;
    end
    rev_q_r <= rev_mem[rev_ra];
  end

  // control and working registers
  ftl_state_t     st_r, st_nxt;
  ftl_phase_t     ph_r, ph_nxt;
  logic [3:0]     cmd_r, cmd_nxt;
  logic [31:0]    blk_r, blk_nxt;
  logic [63:0]    page_r, page_nxt;
  logic [RAW-1:0] slot_r, slot_nxt;
  logic           need_new_r, need_new_nxt;
  logic [IW-1:0]  idx_r, idx_nxt;
  logic [31:0]    count_r, count_nxt;
  logic [16:0]    cfg_r;
  ftl_out_t       res_r, res_nxt;
  ftl_out_t       out_r, out_nxt;
  logic           out_valid_r, out_valid_nxt;

  // effective block limit, saturated at the forward depth
  logic [31:0] lim;
  assign lim = (32'(cfg_r) > FD32) ? FD32 : 32'(cfg_r);

  assign in_ready  = (st_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // fold request shared by all paths that need a reverse slot
  logic        mod_go;
  logic [63:0] mod_src;
  ftl_phase_t  mod_ph;

  logic [31:0]   idx_inc;
  logic          is_fwd;

  always_comb begin
    st_nxt        = st_r;
    ph_nxt        = ph_r;
    cmd_nxt       = cmd_r;
    blk_nxt       = blk_r;
    page_nxt      = page_r;
    slot_nxt      = slot_r;
    need_new_nxt  = need_new_r;
    idx_nxt       = idx_r;
    count_nxt     = count_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    fwd_we = 1'b0;
    fwd_wa = blk_r[FAW-1:0];
    fwd_wd = '0;
    fwd_ra = blk_r[FAW-1:0];
    rev_we = 1'b0;
    rev_wa = slot_r;
    rev_wd = '0;
    rev_ra = slot_r;
    mod_go  = 1'b0;
    mod_src = page_r;
    mod_ph  = PH_NEW;
    idx_inc = 32'(idx_r) + 32'd1;
    is_fwd  = 1'b0;

    // result beat leaves the output register
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (st_r)
      // wipe both tables after reset
      ST_INIT: begin
        fwd_wa = idx_r[FAW-1:0];
        rev_wa = idx_r[RAW-1:0];
        fwd_we = (32'(idx_r) < FD32);
        rev_we = (32'(idx_r) < RD32);
        idx_nxt = idx_r + IW'(1);
        if (idx_inc == MD32) begin
          idx_nxt = '0;
          st_nxt  = ST_IDLE;
        end
      end

      ST_IDLE: begin
        fwd_ra = in_data.logical_block[FAW-1:0];
        if (in_valid) begin
          cmd_nxt  = in_data.command;
          blk_nxt  = in_data.logical_block;
          page_nxt = in_data.physical_page;
          res_nxt  = '0;
          is_fwd   = in_data.command inside {CMD_LOOKUP, CMD_INSERT, CMD_REMOVE,
                                             CMD_UPDATE, CMD_SET, CMD_CLEAR};
          if (in_data.command > CMD_COUNT ||
              (is_fwd && !(in_data.logical_block < lim))) begin
            res_nxt.status = STS_INVALID;
            st_nxt = ST_RESP;
          end else begin
            case (in_data.command)
              CMD_RLOOKUP: begin
                mod_go  = 1'b1;
                mod_src = in_data.physical_page;
                mod_ph  = PH_RLK;
              end
              CMD_REBUILD: begin
                idx_nxt   = '0;
                count_nxt = '0;
                st_nxt    = ST_RCLR;
              end
              CMD_COUNT: begin
                res_nxt.mapped_count = count_r;
                st_nxt = ST_RESP;
              end
              default: begin
                // forward read issued now, data next cycle
                st_nxt = ST_FEXEC;
              end
            endcase
          end
        end
      end

      // forward entry is in fwd_q_r
      ST_FEXEC: begin
        need_new_nxt = 1'b0;
        st_nxt = ST_RESP;
        case (cmd_r)
          CMD_LOOKUP: begin
            if (!fwd_q_r[64]) begin
              res_nxt.status = STS_NOENT;
            end else begin
              res_nxt.page_out = fwd_q_r[63:0];
            end
          end
          CMD_SET: begin
            fwd_we = 1'b1;
            fwd_wd = {1'b1, page_r};
          end
          CMD_CLEAR: begin
            fwd_we = 1'b1;
          end
          CMD_REMOVE: begin
            if (!fwd_q_r[64]) begin
              res_nxt.status = STS_NOENT;
            end else begin
              fwd_we    = 1'b1;
              count_nxt = count_r - 32'd1;
              mod_go    = 1'b1;
              mod_src   = fwd_q_r[63:0];
              mod_ph    = PH_OLD;
            end
          end
          CMD_INSERT: begin
            fwd_we    = 1'b1;
            fwd_wd    = {1'b1, page_r};
            count_nxt = count_r + 32'd1;
            mod_go    = 1'b1;
          end
          CMD_UPDATE: begin
            fwd_we = 1'b1;
            fwd_wd = {1'b1, page_r};
            mod_go = 1'b1;
            if (fwd_q_r[64]) begin
              // old slot is dropped first, then the new one written
              res_nxt.page_out       = fwd_q_r[63:0];
              res_nxt.old_page_valid = 1'b1;
              need_new_nxt = 1'b1;
              mod_src      = fwd_q_r[63:0];
              mod_ph       = PH_OLD;
            end else begin
              count_nxt = count_r + 32'd1;
            end
          end
          default: begin
          end
        endcase
      end

      // reverse slot known, apply the pending action
      ST_SLOT: begin
        case (ph_r)
          PH_OLD: begin
            rev_we = 1'b1;
            if (need_new_r) begin
              mod_go = 1'b1;
            end else begin
              st_nxt = ST_RESP;
            end
          end
          PH_NEW: begin
            rev_we = 1'b1;
            rev_wd = {1'b1, blk_r[15:0]};
            st_nxt = ST_RESP;
          end
          PH_RLK: begin
            st_nxt = ST_RRD;
          end
          default: begin
            rev_we = 1'b1;
            rev_wd = {1'b1, idx_inc[15:0] - 16'd1};
            idx_nxt = idx_r + IW'(1);
            st_nxt  = (idx_inc == lim) ? ST_RESP : ST_SCAN_RD;
          end
        endcase
      end

      ST_RRD: begin
        if (!rev_q_r[16]) begin
          res_nxt.status = STS_NOENT;
        end else begin
          res_nxt.block_out = rev_q_r[15:0];
        end
        st_nxt = ST_RESP;
      end

      // rebuild: clear the reverse table
      ST_RCLR: begin
        rev_we  = 1'b1;
        rev_wa  = idx_r[RAW-1:0];
        idx_nxt = idx_r + IW'(1);
        if (idx_inc == RD32) begin
          idx_nxt = '0;
          st_nxt  = (lim == 32'd0) ? ST_RESP : ST_SCAN_RD;
        end
      end

      // rebuild: walk the forward table in block order
      ST_SCAN_RD: begin
        fwd_ra = idx_r[FAW-1:0];
        st_nxt = ST_SCAN_CHK;
      end

      ST_SCAN_CHK: begin
        if (fwd_q_r[64]) begin
          count_nxt = count_r + 32'd1;
          mod_go    = 1'b1;
          mod_src   = fwd_q_r[63:0];
          mod_ph    = PH_SCAN;
        end else begin
          idx_nxt = idx_r + IW'(1);
          st_nxt  = (idx_inc == lim) ? ST_RESP : ST_SCAN_RD;
        end
      end

      // hand the result to the output register once it is free
      ST_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          st_nxt        = ST_IDLE;
        end
      end

      default: begin
        st_nxt = ST_IDLE;
      end
    endcase

    // start a slot fold: xor fold, the low bits give the slot of the power of two table
    if (mod_go) begin
      slot_nxt = RAW'(mod_src ^ (mod_src >> FOLD_SHIFT));
      ph_nxt   = mod_ph;
      st_nxt   = ST_SLOT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_INIT;
      idx_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      cfg_r       <= 17'h10000;
    end else begin
      st_r        <= st_nxt;
      idx_r       <= idx_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        cfg_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    ph_r       <= ph_nxt;
    cmd_r      <= cmd_nxt;
    blk_r      <= blk_nxt;
    page_r     <= page_nxt;
    slot_r     <= slot_nxt;
    need_new_r <= need_new_nxt;
    res_r      <= res_nxt;
    out_r      <= out_nxt;
  end

endmodule
`default_nettype wire

FILE: sim/ftl_page_map_table_test.sv
// testbench for the flash page map table: directed and random commands against a predictor
module ftl_page_map_table_test;
  import ftl_pkg::*;

  localparam int unsigned FWD_DEPTH = 65536;
  localparam int unsigned REV_DEPTH = 65536;
  localparam logic [63:0] COLLIDE_BIT = 64'h1 << 40; // flips a bit outside the slot fold

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  ftl_in_t     in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  ftl_out_t    out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [16:0] cfg_data = '0;

  always #4 clk = ~clk;

  ftl_page_map_table u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // predictor state: sparse copies of both tables, the count and the register
  bit          map_fwd_valid[int];
  logic [63:0] map_fwd_page[int];
  bit          map_rev_valid[int];
  logic [15:0] map_rev_block[int];
  logic [31:0] map_count = '0;
  logic [16:0] blocks_used = 17'd65536;

  ftl_out_t    expected_results[$];
  logic [63:0] page_pool[$];
  int          mismatches = 0;
  int          beats_sent = 0;
  int          beats_checked = 0;
  int          rebuilds_sent = 0;

  // idle shaping: percent of beats the sender delays, percent of cycles the receiver stalls, plus a long receiver hold
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          recv_hold = 0;

  function automatic int fold_slot(logic [63:0] page);
    logic [63:0] f;
    f = page ^ (page >> FOLD_SHIFT);
    return int'(f % REV_DEPTH);
  endfunction

  function automatic longint unsigned cur_limit();
    return (blocks_used > FWD_DEPTH) ? FWD_DEPTH : longint'(blocks_used);
  endfunction

  function automatic bit is_mapped(int b);
    return map_fwd_valid.exists(b) && map_fwd_valid[b];
  endfunction

  function automatic void put_rev(logic [63:0] page, int b);
    int s;
    s = fold_slot(page);
    map_rev_block[s] = b[15:0];
    map_rev_valid[s] = 1'b1;
  endfunction

  // works out the result of one command and advances the predicted tables
  function automatic ftl_out_t predict_map(ftl_in_t c);
    ftl_out_t r;
    longint unsigned lim;
    int b;
    int s;
    bit fwd_cmd;
    r = '0;
    r.status = STS_OK;
    lim = cur_limit();
    b = int'(c.logical_block[15:0]);
    fwd_cmd = c.command inside {CMD_LOOKUP, CMD_INSERT, CMD_REMOVE, CMD_UPDATE,
                                CMD_SET, CMD_CLEAR};
    if (c.command > CMD_COUNT || (fwd_cmd && longint'(c.logical_block) >= lim)) begin
      r.status = STS_INVALID;
      return r;
    end
    case (c.command)
      CMD_LOOKUP: begin
        if (!is_mapped(b)) r.status = STS_NOENT;
        else r.page_out = map_fwd_page[b];
      end
      CMD_RLOOKUP: begin
        s = fold_slot(c.physical_page);
        if (!(map_rev_valid.exists(s) && map_rev_valid[s])) r.status = STS_NOENT;
        else r.block_out = map_rev_block[s];
      end
      CMD_INSERT: begin
        map_fwd_page[b] = c.physical_page;
        map_fwd_valid[b] = 1'b1;
        put_rev(c.physical_page, b);
        map_count++;
      end
      CMD_REMOVE: begin
        if (!is_mapped(b)) begin
          r.status = STS_NOENT;
        end else begin
          s = fold_slot(map_fwd_page[b]);
          map_fwd_valid[b] = 1'b0;
          map_fwd_page[b] = '0;
          map_rev_valid[s] = 1'b0;
          map_rev_block[s] = '0;
          map_count--;
        end
      end
      CMD_UPDATE: begin
        if (is_mapped(b)) begin
          r.page_out = map_fwd_page[b];
          r.old_page_valid = 1'b1;
          map_rev_valid[fold_slot(map_fwd_page[b])] = 1'b0;
          map_count--;
        end
        map_fwd_page[b] = c.physical_page;
        map_fwd_valid[b] = 1'b1;
        put_rev(c.physical_page, b);
        map_count++;
      end
      CMD_SET: begin
        map_fwd_page[b] = c.physical_page;
        map_fwd_valid[b] = 1'b1;
      end
      CMD_CLEAR: begin
        map_fwd_valid[b] = 1'b0;
        map_fwd_page[b] = '0;
      end
      CMD_REBUILD: begin
        map_rev_valid.delete();
        map_rev_block.delete();
        map_count = '0;
        // associative arrays walk their keys in ascending order
        foreach (map_fwd_valid[k]) begin
          if (longint'(k) < lim && map_fwd_valid[k]) begin
            put_rev(map_fwd_page[k], k);
            map_count++;
          end
        end
      end
      default: r.mapped_count = map_count;
    endcase
    return r;
  endfunction

  // offers one command beat; valid stays up across back-to-back beats
  task automatic send_cmd(logic [3:0] cmd, logic [31:0] blk, logic [63:0] page);
    ftl_in_t c;
    c.command = cmd;
    c.logical_block = blk;
    c.physical_page = page;
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= c;
    // in_ready is stable at the falling edge, so the beat goes at the next rising edge
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    expected_results.push_back(predict_map(c));
    beats_sent++;
    if (cmd == CMD_REBUILD) rebuilds_sent++;
    if (cmd inside {CMD_INSERT, CMD_UPDATE, CMD_SET}) begin
      page_pool.push_back(page);
      if (page_pool.size() > 32) void'(page_pool.pop_front());
    end
    @(posedge clk);
  endtask

  task automatic quiet_input();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // drains all results, lets the block settle, then writes the block limit
  task automatic write_limit(logic [16:0] value);
    quiet_input();
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    cfg_valid <= 1'b0;
    blocks_used = value;
  endtask

  // receiver: random stalls, and a long hold when one is requested
  always @(posedge clk) begin
    if (recv_hold > 0) begin
      out_ready <= 1'b0;
      recv_hold <= recv_hold - 1;
    end else begin
      out_ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // checker: a result beat is taken at the rising edge after a falling edge that sees it
  always @(negedge clk) begin
    ftl_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", out_data);
      end else begin
        want = expected_results.pop_front();
        beats_checked++;
        if (out_data.status !== want.status || out_data.page_out !== want.page_out ||
            out_data.old_page_valid !== want.old_page_valid ||
            out_data.block_out !== want.block_out ||
            out_data.mapped_count !== want.mapped_count) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d mismatch: expected %p, got %p", beats_checked, want, out_data);
        end
      end
    end
  end

  function automatic logic [63:0] rand_page();
    return {$urandom, $urandom};
  endfunction

  // the special cases, each command at least once and the field extremes
  task automatic test_directed();
    logic [63:0] p;
    p = 64'h0123_4567_89ab_cdef;
    send_cmd(CMD_LOOKUP, 32'd0, '0);          // empty table
    send_cmd(CMD_RLOOKUP, '0, '1);
    send_cmd(CMD_REMOVE, 32'd7, '0);
    send_cmd(CMD_INSERT, 32'd0, '0);
    send_cmd(CMD_INSERT, 32'd65535, '1);
    send_cmd(CMD_LOOKUP, 32'd65535, '0);
    send_cmd(CMD_RLOOKUP, '0, '1);
    send_cmd(CMD_INSERT, 32'd3, p);
    send_cmd(CMD_INSERT, 32'd3, rand_page()); // overwrite leaves the old slot behind
    send_cmd(CMD_RLOOKUP, '0, p);
    send_cmd(CMD_INSERT, 32'd9, p ^ COLLIDE_BIT); // same reverse slot, latest wins
    send_cmd(CMD_RLOOKUP, '0, p);
    send_cmd(CMD_UPDATE, 32'd3, p);           // returns the old page
    send_cmd(CMD_UPDATE, 32'd20, p);          // nothing to return
    send_cmd(CMD_REMOVE, 32'd3, '0);
    send_cmd(CMD_SET, 32'd40, 64'hdead_beef_0000_0001);
    send_cmd(CMD_CLEAR, 32'd65535, '0);
    send_cmd(CMD_LOOKUP, 32'd40, '0);
    send_cmd(CMD_LOOKUP, 32'hffff_ffff, '0);  // out of range
    send_cmd(CMD_INSERT, 32'd65536, p);
    send_cmd(4'd9, '0, '0);
    send_cmd(4'd15, '1, '1);
    send_cmd(CMD_COUNT, '0, '0);
    send_cmd(CMD_REBUILD, '0, '0);            // full limit scan
    send_cmd(CMD_COUNT, '0, '0);
  endtask

  // limit register extremes: zero, saturated above the table and small
  task automatic test_limits();
    write_limit(17'd0);
    send_cmd(CMD_LOOKUP, 32'd0, '0);
    send_cmd(CMD_INSERT, 32'd0, rand_page());
    send_cmd(CMD_REBUILD, '0, '0);
    send_cmd(CMD_COUNT, '0, '0);
    write_limit(17'h1ffff);
    send_cmd(CMD_LOOKUP, 32'd65535, '0);
    send_cmd(CMD_INSERT, 32'd65536, '0);
    write_limit(17'd5);
    send_cmd(CMD_SET, 32'd4, rand_page());
    send_cmd(CMD_SET, 32'd5, rand_page());
    send_cmd(CMD_REBUILD, '0, '0);
    send_cmd(CMD_COUNT, '0, '0);
  endtask

  // mostly well formed traffic on a small block range so entries get hit again
  task automatic random_cmds(int n, int unsigned blk_hi);
    int unsigned pick;
    logic [3:0] cmd;
    logic [31:0] blk;
    logic [63:0] page;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 16) cmd = CMD_LOOKUP;
      else if (pick < 28) cmd = CMD_RLOOKUP;
      else if (pick < 46) cmd = CMD_INSERT;
      else if (pick < 58) cmd = CMD_REMOVE;
      else if (pick < 72) cmd = CMD_UPDATE;
      else if (pick < 80) cmd = CMD_SET;
      else if (pick < 87) cmd = CMD_CLEAR;
      else if (pick < 94) cmd = CMD_COUNT;
      else if (pick < 97) cmd = 4'($urandom_range(15, 9));
      else cmd = CMD_LOOKUP;
      // rebuild clears the whole reverse table, so keep it rare
      if ($urandom_range(399) == 0 && cur_limit() <= 64) cmd = CMD_REBUILD;
      pick = $urandom_range(99);
      if (pick < 85) blk = $urandom_range(blk_hi);
      else if (pick < 93) blk = 32'(cur_limit()) - 32'($urandom_range(1)) + 32'($urandom_range(1));
      else blk = $urandom;
      pick = $urandom_range(99);
      if (pick < 60 && page_pool.size() != 0) begin
        page = page_pool[$urandom_range(page_pool.size() - 1)];
        if ($urandom_range(9) == 0) page ^= COLLIDE_BIT;
      end else begin
        page = rand_page();
      end
      send_cmd(cmd, blk, page);
    end
  endtask

  task automatic test_random();
    write_limit(17'd48);
    send_idle_pct = 0;  recv_stall_pct = 0;
    random_cmds(300, 63);
    send_idle_pct = 51; recv_stall_pct = 0;
    random_cmds(300, 63);
    send_idle_pct = 0;  recv_stall_pct = 51;
    random_cmds(300, 63);
    send_idle_pct = 18; recv_stall_pct = 18;
    random_cmds(250, 63);
    write_limit(17'd65536);
    random_cmds(200, 65535);
  endtask

  // receiver holds off while commands keep coming, then the sender drains
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    recv_hold = 300;
    random_cmds(30, 31);
    quiet_input();
    while (expected_results.size() != 0) @(posedge clk);
    random_cmds(20, 31);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_limits();
    test_random();
    test_backpressure();
    quiet_input();
    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("covered %0d command beats, %0d rebuilds, limits 0, 5, 48, 65536, 131071",
             beats_sent, rebuilds_sent);
    $display("checked %0d result beats, %0d mismatches", beats_checked, mismatches);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // run limit, far above the slowest correct run including the clearing passes
  initial begin
    #40000000;
    $display("timeout with %0d results outstanding", expected_results.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/ftl_pkg.sv
hw/rtl/ftl_page_map_table.sv
sim/ftl_page_map_table_test.sv
